@@ hw/rtl/ftpc_pkg.sv @@
// Shared types, command codes and helpers for the TMz PML cell update pipeline.
package ftpc_pkg;

  localparam logic [2:0] CMD_HX_PML  = 3'd0;
  localparam logic [2:0] CMD_HY_PML  = 3'd1;
  localparam logic [2:0] CMD_HX_BULK = 3'd2;
  localparam logic [2:0] CMD_HY_BULK = 3'd3;
  localparam logic [2:0] CMD_DZ_PML  = 3'd4;
  localparam logic [2:0] CMD_DZ_BULK = 3'd5;

  localparam logic [1:0] REG_INV_DX       = 2'd0;
  localparam logic [1:0] REG_INV_DY       = 2'd1;
  localparam logic [1:0] REG_COURANT_STEP = 2'd2;

  localparam logic [30:0] CFG_RESET = 31'd65536;

  // quotient bits of (|Dz| << 16) / permittivity
  localparam int DivSteps = 48;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [31:0] near_a;
    logic signed [31:0] near_b;
    logic signed [31:0] near_c;
    logic signed [31:0] near_d;
    logic signed [31:0] old_field;
    logic signed [31:0] integral_in;
    logic signed [31:0] coef_m1;
    logic signed [31:0] coef_m2;
    logic signed [31:0] coef_m3;
    logic [30:0]        permittivity;
  } cell_t;

  typedef struct packed {
    logic               is_dz;
    logic [30:0]        permittivity;
    logic signed [31:0] new_field;
    logic signed [31:0] integral_out;
  } upd_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/fdtd_tmz_pml_cell_update.sv @@
// Top level: TMz FDTD cell update with PML, stream in, stream out, config registers.
//
//   channel   dir   handshake            payload
//   s_*       in    s_tvalid/s_tready    s_tdata (fields), s_tuser (cmd)
//   m_*       out   m_tvalid/m_tready    m_tdata (new_field, integral_out, electric_out)
//   cfg_*     in    cfg_we               cfg_index, cfg_data
//
// One cell enters per clock while no stall holds the pipe; 3 curl, 3 update and 50 divider stages.
// The divider sets the depth: one quotient bit per stage over 48 stages.
// Synchronous reset clears all valid bits and loads the three config registers with 1.0.
// A stall at m_tready freezes the whole pipe; s_tready drops with it.
module fdtd_tmz_pml_cell_update (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // near_a, near_b, near_c, near_d, old_field, integral_in, coef_m1, coef_m2,
  // coef_m3, permittivity, zero pad
  input  logic [319:0] s_tdata,
  // cmd
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // new_field, integral_out, electric_out
  output logic [95:0]  m_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [30:0]  cfg_data
);
  import ftpc_pkg::*;

  logic               ce;
  logic [30:0]        inv_dx, inv_dy, courant_step;
  cell_t              in_cell, curl_cell;
  logic               curl_valid, upd_valid;
  logic signed [31:0] curl;
  upd_t               upd;
  logic signed [31:0] new_field, integral_out, electric_out;

  assign ce = !m_tvalid || m_tready;
  assign s_tready = ce;

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_dx <= CFG_RESET;
      inv_dy <= CFG_RESET;
      courant_step <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INV_DX: inv_dx <= cfg_data;
        REG_INV_DY: inv_dy <= cfg_data;
        REG_COURANT_STEP: courant_step <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_cell.cmd          = s_tuser;
    in_cell.near_a       = s_tdata[31:0];
    in_cell.near_b       = s_tdata[63:32];
    in_cell.near_c       = s_tdata[95:64];
    in_cell.near_d       = s_tdata[127:96];
    in_cell.old_field    = s_tdata[159:128];
    in_cell.integral_in  = s_tdata[191:160];
    in_cell.coef_m1      = s_tdata[223:192];
    in_cell.coef_m2      = s_tdata[255:224];
    in_cell.coef_m3      = s_tdata[287:256];
    in_cell.permittivity = s_tdata[318:288];
  end

  ftpc_curl u_curl (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (s_tvalid),
    .in_cell   (in_cell),
    .inv_dx    (inv_dx),
    .inv_dy    (inv_dy),
    .out_valid (curl_valid),
    .out_cell  (curl_cell),
    .curl      (curl)
  );

  ftpc_update u_update (
    .clk          (clk),
    .rst          (rst),
    .ce           (ce),
    .in_valid     (curl_valid),
    .in_cell      (curl_cell),
    .curl         (curl),
    .courant_step (courant_step),
    .out_valid    (upd_valid),
    .upd          (upd)
  );

  ftpc_div u_div (
    .clk          (clk),
    .rst          (rst),
    .ce           (ce),
    .in_valid     (upd_valid),
    .upd          (upd),
    .out_valid    (m_tvalid),
    .new_field    (new_field),
    .integral_out (integral_out),
    .electric_out (electric_out)
  );

  assign m_tdata = {electric_out, integral_out, new_field};

endmodule

@@ hw/rtl/ftpc_curl.sv @@
// Curl pipeline: neighbor differences, grid-step products, floor and saturate.
module ftpc_curl (
  input  logic                clk,
  input  logic                rst,
  input  logic                ce,
  input  logic                in_valid,
  input  ftpc_pkg::cell_t     in_cell,
  input  logic [30:0]         inv_dx,
  input  logic [30:0]         inv_dy,
  output logic                out_valid,
  output ftpc_pkg::cell_t     out_cell,
  output logic signed [31:0]  curl
);
  import ftpc_pkg::*;

  logic               va, vb;
  cell_t              cell_a, cell_b;
  logic signed [32:0] d1, d2;
  logic [30:0]        k1, k2;
  logic signed [64:0] p1, p2;
  logic signed [32:0] d1_next, d2_next;
  logic [30:0]        k1_next, k2_next;
  logic signed [65:0] t, ch;
  logic signed [31:0] curl_next;

  always_comb begin
    if (in_cell.cmd[2]) begin
      d1_next = 33'(in_cell.near_a) - 33'(in_cell.near_b);
      k1_next = inv_dx;
    end else begin
      d1_next = 33'(in_cell.near_b) - 33'(in_cell.near_a);
      k1_next = in_cell.cmd[0] ? inv_dx : inv_dy;
    end
    d2_next = 33'(in_cell.near_c) - 33'(in_cell.near_d);
    k2_next = inv_dy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      va <= in_valid;
      vb <= va;
      out_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      cell_a <= in_cell;
      d1 <= d1_next;
      d2 <= d2_next;
      k1 <= k1_next;
      k2 <= k2_next;
      cell_b <= cell_a;
      p1 <= d1 * $signed({1'b0, k1});
      p2 <= d2 * $signed({1'b0, k2});
      out_cell <= cell_b;
      curl <= curl_next;
    end
  end

  always_comb begin
    t = (cell_b.cmd == CMD_HY_PML) ? -66'(p1) : 66'(p1);
    ch = (66'(p1) >>> 16) - (66'(p2) >>> 16);
    curl_next = cell_b.cmd[2] ? sat32(ch) : sat32(t >>> 16);
  end

endmodule

@@ hw/rtl/ftpc_update.sv @@
// Field update pipeline: integral, coefficient products, sum and saturate.
module ftpc_update (
  input  logic               clk,
  input  logic               rst,
  input  logic               ce,
  input  logic               in_valid,
  input  ftpc_pkg::cell_t    in_cell,
  input  logic signed [31:0] curl,
  input  logic [30:0]        courant_step,
  output logic               out_valid,
  output ftpc_pkg::upd_t     upd
);
  import ftpc_pkg::*;

  logic               vd, ve;
  cell_t              cell_d, cell_e;
  logic signed [31:0] curl_d, io_d, io_e, io_next;
  logic signed [63:0] q1, q3;
  logic signed [64:0] q2;
  logic signed [32:0] k2;
  logic signed [65:0] f1, f2, f3, sum;
  upd_t               upd_next;

  always_comb begin
    if (in_cell.cmd == CMD_HX_PML || in_cell.cmd == CMD_HY_PML) begin
      io_next = sat32(66'(in_cell.integral_in) + 66'(curl));
    end else if (in_cell.cmd == CMD_DZ_PML) begin
      io_next = sat32(66'(in_cell.integral_in) + 66'(in_cell.old_field));
    end else begin
      io_next = in_cell.integral_in;
    end
  end

  assign k2 = (cell_d.cmd == CMD_DZ_BULK) ? $signed({2'b00, courant_step})
                                          : 33'(cell_d.coef_m2);

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
      ve <= 1'b0;
      out_valid <= 1'b0;
    end else if (ce) begin
      vd <= in_valid;
      ve <= vd;
      out_valid <= ve;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      cell_d <= in_cell;
      curl_d <= curl;
      io_d <= io_next;
      cell_e <= cell_d;
      io_e <= io_d;
      q1 <= cell_d.coef_m1 * cell_d.old_field;
      q2 <= k2 * curl_d;
      q3 <= cell_d.coef_m3 * io_d;
      upd <= upd_next;
    end
  end

  always_comb begin
    f1 = 66'(q1) >>> 16;
    f2 = 66'(q2) >>> 16;
    f3 = 66'(q3) >>> 16;
    unique case (cell_e.cmd)
      CMD_HX_PML, CMD_HY_PML, CMD_DZ_PML: sum = f1 + f2 + f3;
      CMD_HX_BULK: sum = 66'(cell_e.old_field) - f2;
      CMD_HY_BULK, CMD_DZ_BULK: sum = 66'(cell_e.old_field) + f2;
      default: sum = 66'(cell_e.old_field);
    endcase
    upd_next.is_dz = (cell_e.cmd == CMD_DZ_PML) || (cell_e.cmd == CMD_DZ_BULK);
    upd_next.permittivity = cell_e.permittivity;
    upd_next.new_field = sat32(sum);
    upd_next.integral_out = io_e;
  end

endmodule

@@ hw/rtl/ftpc_div.sv @@
// Pipelined restoring divider for Ez = Dz / permittivity, one quotient bit a stage.
module ftpc_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               ce,
  input  logic               in_valid,
  input  ftpc_pkg::upd_t     upd,
  output logic               out_valid,
  output logic signed [31:0] new_field,
  output logic signed [31:0] integral_out,
  output logic signed [31:0] electric_out
);
  import ftpc_pkg::*;

  logic                v   [DivSteps+1];
  upd_t                side[DivSteps+1];
  logic                neg [DivSteps+1];
  logic [30:0]         rem [DivSteps+1];
  logic [DivSteps-1:0] num [DivSteps+1];
  logic [31:0]         mag;
  logic [DivSteps-1:0] q;
  logic signed [31:0]  ez_next;

  assign mag = upd.new_field[31] ? (~upd.new_field + 32'd1) : upd.new_field;

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (ce) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      side[0] <= upd;
      neg[0] <= upd.new_field[31];
      rem[0] <= '0;
      num[0] <= {mag, 16'd0};
    end
  end

  for (genvar i = 0; i < DivSteps; i++) begin : g_step
    logic [31:0] rt;
    logic        take;
    assign rt = {rem[i], num[i][DivSteps-1]};
    assign take = rt >= {1'b0, side[i].permittivity};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (ce) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        side[i+1] <= side[i];
        neg[i+1] <= neg[i];
        rem[i+1] <= take ? 31'(rt - {1'b0, side[i].permittivity}) : rt[30:0];
        num[i+1] <= {num[i][DivSteps-2:0], take};
      end
    end
  end

  assign q = num[DivSteps];

  always_comb begin
    if (!side[DivSteps].is_dz) begin
      ez_next = '0;
    end else if (side[DivSteps].permittivity == '0) begin
      if (side[DivSteps].new_field == '0) begin
        ez_next = '0;
      end else begin
        ez_next = neg[DivSteps] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
    end else if (neg[DivSteps]) begin
      ez_next = (q > 48'd2147483648) ? 32'sh8000_0000 : 32'(-q);
    end else begin
      ez_next = (q > 48'd2147483647) ? 32'sh7FFF_FFFF : q[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= v[DivSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      new_field <= side[DivSteps].new_field;
      integral_out <= side[DivSteps].integral_out;
      electric_out <= ez_next;
    end
  end

endmodule
